FILE: design/kpi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyframe pose interpolator package
// Sizes, command codes, the decoded command record and the sequencer states.
// ----------------------------------------------------------------------------
package kpi_pkg;

	localparam int MOTIONS = 16;
	localparam int KEYS    = 16;
	localparam int PARTS   = 16;

	localparam int MOT_W  = (MOTIONS > 1) ? $clog2(MOTIONS) : 1;
	localparam int KEY_W  = $clog2(KEYS);
	localparam int PART_W = (PARTS > 1) ? $clog2(PARTS) : 1;
	localparam int CNT_W  = $clog2(KEYS + 1);
	localparam int CUR_W  = $clog2(MOTIONS + 1);
	localparam int PCNT_W = $clog2(PARTS + 1);
	localparam int NP_W   = 5;

	localparam int POSE_DEPTH  = MOTIONS * KEYS * PARTS * 6;
	localparam int POSE_AW     = $clog2(POSE_DEPTH);
	localparam int FRAME_DEPTH = MOTIONS * KEYS;
	localparam int FRAME_AW    = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

	localparam logic signed [31:0] PI_Q16 = 32'sd205887;

	localparam logic [1:0] MODE_POSE   = 2'd0;
	localparam logic [1:0] MODE_FRAME  = 2'd1;
	localparam logic [1:0] MODE_HEADER = 2'd2;
	localparam logic [1:0] MODE_TICK   = 2'd3;

	typedef enum logic [2:0] {
		OP_POSE,
		OP_OFFSET,
		OP_ROOT,
		OP_FRAME,
		OP_HEADER,
		OP_TICK
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [MOT_W-1:0]   motion;
		logic [KEY_W-1:0]   key;
		logic [PART_W-1:0]  part;
		logic [2:0]         axis;
		logic [31:0]        data;
		logic               loop_f;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TICK,
		ST_FRD,
		ST_CHECK,
		ST_ADDR,
		ST_MUL,
		ST_ABS,
		ST_DIV,
		ST_SUM,
		ST_OUT,
		ST_KEYUPD,
		ST_NULL
	} state_t;

endpackage
`default_nettype wire

FILE: design/kpi_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyframe pose interpolator command channel
// Carries load and tick items into the block.
// ----------------------------------------------------------------------------
interface kpi_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [3:0]         motion_type;
	logic [3:0]         key_index;
	logic [3:0]         part_index;
	logic [3:0]         axis;
	logic signed [31:0] value;
	logic               loop_flag;

	modport source (output valid, mode, motion_type, key_index, part_index, axis, value,
		loop_flag, input ready);
	modport sink (input valid, mode, motion_type, key_index, part_index, axis, value,
		loop_flag, output ready);
endinterface
`default_nettype wire

FILE: design/kpi_pose_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyframe pose interpolator pose channel
// Carries one interpolated part pose per item out of the block.
// ----------------------------------------------------------------------------
interface kpi_pose_if;
	logic               valid;
	logic               ready;
	logic [3:0]         part_out;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] rot_x;
	logic signed [31:0] rot_y;
	logic signed [31:0] rot_z;
	logic               pose_valid;
	logic               motion_end;
	logic               last;

	modport source (output valid, part_out, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z,
		pose_valid, motion_end, last, input ready);
	modport sink (input valid, part_out, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z,
		pose_valid, motion_end, last, output ready);
endinterface
`default_nettype wire

FILE: design/kpi_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyframe pose interpolator front end
// Accepts items, drops those that change nothing and decodes the rest.
// ----------------------------------------------------------------------------
module kpi_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	kpi_cmd_if.sink            cmd,
	output kpi_pkg::cmd_t      q_cmd,
	output logic               q_valid,
	input  wire logic          q_ready
);
	kpi_pkg::cmd_t dec;
	logic          keep;
	logic          m_ok;
	logic          k_ok;
	logic          p_ok;
	logic          valid_s1;
	kpi_pkg::cmd_t cmd_s1;

	assign m_ok = 32'(cmd.motion_type) < 32'(kpi_pkg::MOTIONS);
	assign k_ok = 32'(cmd.key_index) < 32'(kpi_pkg::KEYS);
	assign p_ok = 32'(cmd.part_index) < 32'(kpi_pkg::PARTS);

	always_comb begin
		dec.op     = kpi_pkg::OP_TICK;
		dec.motion = kpi_pkg::MOT_W'(cmd.motion_type);
		dec.key    = kpi_pkg::KEY_W'(cmd.key_index);
		dec.part   = kpi_pkg::PART_W'(cmd.part_index);
		dec.axis   = cmd.axis[2:0];
		dec.data   = cmd.value;
		dec.loop_f = cmd.loop_flag;
		keep       = 1'b0;
		unique case (cmd.mode)
			kpi_pkg::MODE_POSE: begin
				if (!((!(m_ok && k_ok && p_ok)) && (cmd.axis < 4'd6 || !p_ok))) begin
					if (cmd.axis < 4'd6) begin
						dec.op = kpi_pkg::OP_POSE;
						keep   = 1'b1;
					end else if (cmd.axis < 4'd9) begin
						dec.op   = kpi_pkg::OP_OFFSET;
						dec.axis = 3'(cmd.axis - 4'd6);
						keep     = 1'b1;
					end else if (cmd.axis == 4'd9) begin
						dec.op   = kpi_pkg::OP_ROOT;
						dec.data = {31'd0, cmd.value != 32'sd0};
						keep     = 1'b1;
					end
				end
			end
			kpi_pkg::MODE_FRAME: begin
				dec.op = kpi_pkg::OP_FRAME;
				keep   = m_ok && k_ok;
				if (cmd.value < 32'sd1) begin
					dec.data = 32'd1;
				end else if (cmd.value > 32'sd65535) begin
					dec.data = 32'd65535;
				end else begin
					dec.data = {16'd0, cmd.value[15:0]};
				end
			end
			kpi_pkg::MODE_HEADER: begin
				dec.op = kpi_pkg::OP_HEADER;
				keep   = m_ok;
				if (cmd.value < 32'sd0) begin
					dec.data = 32'd0;
				end else if (cmd.value > 32'(kpi_pkg::KEYS)) begin
					dec.data = 32'(kpi_pkg::KEYS);
				end
			end
			kpi_pkg::MODE_TICK: begin
				dec.op = kpi_pkg::OP_TICK;
				keep   = m_ok;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign cmd.ready = !valid_s1 || q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= keep;
		end else if (q_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= dec;
		end
	end

	assign q_valid = valid_s1;
	assign q_cmd   = cmd_s1;
endmodule
`default_nettype wire

FILE: design/kpi_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyframe pose interpolator command queue
// Two-entry queue of decoded commands between the front and back ends.
// ----------------------------------------------------------------------------
module kpi_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  kpi_pkg::cmd_t      wr_cmd,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	output kpi_pkg::cmd_t      rd_cmd,
	output logic               rd_valid,
	input  wire logic          rd_ready
);
	kpi_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;

	assign wr_ready = count_q != 2'd2;
	assign rd_valid = count_q != 2'd0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end
endmodule
`default_nettype wire

FILE: design/kpi_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyframe pose interpolator back end
// Holds the motion tables, performs writes and plays ticks part by part.
// ----------------------------------------------------------------------------
module kpi_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  kpi_pkg::cmd_t                   q_cmd,
	input  wire logic                       q_valid,
	output logic                            q_ready,
	input  wire logic [kpi_pkg::PCNT_W-1:0] parts,
	kpi_pose_if.source                      pose
);
	kpi_pkg::state_t state_q;
	kpi_pkg::state_t state_d;

	logic signed [31:0] pose_mem [kpi_pkg::POSE_DEPTH];
	logic [15:0]        frame_mem [kpi_pkg::FRAME_DEPTH];
	logic [kpi_pkg::CNT_W-1:0] hdr_cnt_q [kpi_pkg::MOTIONS];
	logic                      hdr_loop_q [kpi_pkg::MOTIONS];
	logic signed [31:0] off_x_q [kpi_pkg::PARTS];
	logic signed [31:0] off_y_q [kpi_pkg::PARTS];
	logic signed [31:0] off_z_q [kpi_pkg::PARTS];
	logic               root_q [kpi_pkg::PARTS];

	logic [kpi_pkg::CUR_W-1:0]  cur_motion_q;
	logic [15:0]                counter_q;
	logic [kpi_pkg::CNT_W-1:0]  key_now_q;
	logic [kpi_pkg::CNT_W-1:0]  key_next_q;
	logic [kpi_pkg::CNT_W-1:0]  keys_q;
	logic                       ended_q;
	logic [kpi_pkg::MOT_W-1:0]  tm_q;
	logic [15:0]                frames_q;
	logic [kpi_pkg::PART_W-1:0] part_q;
	logic [2:0]                 axis_q;

	logic signed [31:0] cur_rd_q;
	logic signed [31:0] nxt_rd_q;
	logic [15:0]        fr_rd_q;
	logic signed [31:0] cur_q;
	logic signed [49:0] prod_s1;
	logic               neg_q;
	logic [47:0]        num_q;
	logic [15:0]        rem_q;
	logic [5:0]         div_cnt_q;
	logic signed [31:0] res_q [6];

	logic               out_valid_q;
	logic [3:0]         out_part_q;
	logic signed [31:0] out_res_q [6];
	logic               out_pv_q;
	logic               out_end_q;
	logic               out_last_q;

	logic                        pop;
	logic [kpi_pkg::POSE_AW-1:0] pose_waddr;
	logic [kpi_pkg::POSE_AW-1:0] raddr_cur;
	logic [kpi_pkg::POSE_AW-1:0] raddr_nxt;
	logic [kpi_pkg::FRAME_AW-1:0] fr_waddr;
	logic [kpi_pkg::FRAME_AW-1:0] fr_raddr;
	logic [15:0]                 frames_c;
	logic                        active;
	logic                        out_free;
	logic                        last_part;
	logic [16:0]                 rem_sh;
	logic                        div_ge;
	logic signed [32:0]          diff;
	logic signed [49:0]          quot;
	logic signed [31:0]          off_sel;
	logic signed [31:0]          pi_sel;
	logic signed [51:0]          sum_v;
	logic signed [31:0]          sat_v;
	logic [kpi_pkg::CNT_W:0]     key_adv;

	function automatic logic [kpi_pkg::POSE_AW-1:0] pidx(
		input logic [kpi_pkg::MOT_W-1:0]  m,
		input logic [kpi_pkg::KEY_W-1:0]  k,
		input logic [kpi_pkg::PART_W-1:0] p,
		input logic [2:0]                 a
	);
		pidx = kpi_pkg::POSE_AW'(((32'(m) * kpi_pkg::KEYS + 32'(k)) * kpi_pkg::PARTS
			+ 32'(p)) * 6 + 32'(a));
	endfunction

	assign pop     = q_valid && q_ready;
	assign q_ready = state_q == kpi_pkg::ST_IDLE;

	assign pose_waddr = pidx(q_cmd.motion, q_cmd.key, q_cmd.part, q_cmd.axis);
	assign raddr_cur  = pidx(tm_q, key_now_q[kpi_pkg::KEY_W-1:0], part_q, axis_q);
	assign raddr_nxt  = pidx(tm_q, key_next_q[kpi_pkg::KEY_W-1:0], part_q, axis_q);
	assign fr_waddr   = kpi_pkg::FRAME_AW'(32'(q_cmd.motion) * kpi_pkg::KEYS
		+ 32'(q_cmd.key));
	assign fr_raddr   = kpi_pkg::FRAME_AW'(32'(tm_q) * kpi_pkg::KEYS
		+ 32'(key_now_q[kpi_pkg::KEY_W-1:0]));

	assign frames_c  = (fr_rd_q == 16'd0) ? 16'd1 : fr_rd_q;
	assign active    = (key_next_q < keys_q) && (32'(key_now_q) < 32'(kpi_pkg::KEYS));
	assign out_free  = !out_valid_q || pose.ready;
	assign last_part = (32'(part_q) + 32'd1) == 32'(parts);
	assign key_adv   = {1'b0, key_now_q} + 1'b1;

	assign rem_sh = {rem_q, num_q[47]};
	assign div_ge = rem_sh >= {1'b0, frames_q};
	assign diff   = {nxt_rd_q[31], nxt_rd_q} - {cur_rd_q[31], cur_rd_q};

	always_comb begin
		quot = neg_q ? -$signed({2'b00, num_q}) : $signed({2'b00, num_q});
		unique case (axis_q)
			3'd0:    off_sel = off_x_q[part_q];
			3'd1:    off_sel = off_y_q[part_q];
			3'd2:    off_sel = off_z_q[part_q];
			default: off_sel = 32'sd0;
		endcase
		pi_sel = (axis_q == 3'd4 && root_q[part_q]) ? kpi_pkg::PI_Q16 : 32'sd0;
		sum_v  = 52'(cur_q) + 52'(quot) + 52'(off_sel) + 52'(pi_sel);
		if (sum_v > 52'sd2147483647) begin
			sat_v = 32'sh7FFFFFFF;
		end else if (sum_v < -52'sd2147483648) begin
			sat_v = 32'sh80000000;
		end else begin
			sat_v = sum_v[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kpi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kpi_pkg::ST_IDLE: begin
				if (pop && q_cmd.op == kpi_pkg::OP_TICK) begin
					state_d = kpi_pkg::ST_TICK;
				end
			end
			kpi_pkg::ST_TICK:  state_d = kpi_pkg::ST_FRD;
			kpi_pkg::ST_FRD:   state_d = kpi_pkg::ST_CHECK;
			kpi_pkg::ST_CHECK: begin
				if (!active) begin
					state_d = kpi_pkg::ST_NULL;
				end else if (parts != '0) begin
					state_d = kpi_pkg::ST_ADDR;
				end else begin
					state_d = kpi_pkg::ST_KEYUPD;
				end
			end
			kpi_pkg::ST_ADDR: state_d = kpi_pkg::ST_MUL;
			kpi_pkg::ST_MUL:  state_d = kpi_pkg::ST_ABS;
			kpi_pkg::ST_ABS:  state_d = kpi_pkg::ST_DIV;
			kpi_pkg::ST_DIV: begin
				if (div_cnt_q == 6'd47) begin
					state_d = kpi_pkg::ST_SUM;
				end
			end
			kpi_pkg::ST_SUM: begin
				state_d = (axis_q == 3'd5) ? kpi_pkg::ST_OUT : kpi_pkg::ST_ADDR;
			end
			kpi_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = last_part ? kpi_pkg::ST_KEYUPD : kpi_pkg::ST_ADDR;
				end
			end
			kpi_pkg::ST_KEYUPD: begin
				state_d = (parts == '0) ? kpi_pkg::ST_NULL : kpi_pkg::ST_IDLE;
			end
			kpi_pkg::ST_NULL: begin
				if (out_free) begin
					state_d = kpi_pkg::ST_IDLE;
				end
			end
			default: state_d = kpi_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_motion_q <= kpi_pkg::CUR_W'(kpi_pkg::MOTIONS);
			counter_q    <= 16'd0;
			key_now_q    <= '0;
			key_next_q   <= '0;
			keys_q       <= '0;
			ended_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < kpi_pkg::PARTS; i++) begin
				off_x_q[i] <= 32'sd0;
				off_y_q[i] <= 32'sd0;
				off_z_q[i] <= 32'sd0;
				root_q[i]  <= 1'b0;
			end
		end else begin
			if (pop && q_cmd.op == kpi_pkg::OP_OFFSET) begin
				unique case (q_cmd.axis)
					3'd0:    off_x_q[q_cmd.part] <= q_cmd.data;
					3'd1:    off_y_q[q_cmd.part] <= q_cmd.data;
					default: off_z_q[q_cmd.part] <= q_cmd.data;
				endcase
			end
			if (pop && q_cmd.op == kpi_pkg::OP_ROOT) begin
				root_q[q_cmd.part] <= q_cmd.data[0];
			end
			if (state_q == kpi_pkg::ST_TICK) begin
				if (cur_motion_q != kpi_pkg::CUR_W'(tm_q)) begin
					cur_motion_q <= kpi_pkg::CUR_W'(tm_q);
					counter_q    <= 16'd1;
					keys_q       <= hdr_cnt_q[tm_q];
					key_now_q    <= '0;
					key_next_q   <= (hdr_cnt_q[tm_q] > kpi_pkg::CNT_W'(1)) ?
						kpi_pkg::CNT_W'(1) : '0;
					ended_q      <= 1'b1;
				end else begin
					counter_q <= counter_q + 16'd1;
					ended_q   <= 1'b0;
				end
			end
			if (state_q == kpi_pkg::ST_CHECK && active && counter_q >= frames_c
				&& key_next_q > key_now_q) begin
				ended_q <= 1'b1;
			end
			if (state_q == kpi_pkg::ST_KEYUPD && counter_q >= frames_q) begin
				counter_q <= 16'd0;
				if (key_next_q > key_now_q) begin
					key_now_q <= key_now_q + 1'b1;
					if (key_adv + 1'b1 >= {1'b0, hdr_cnt_q[tm_q]}) begin
						key_next_q <= hdr_loop_q[tm_q] ? '0 : keys_q;
					end else begin
						key_next_q <= key_next_q + 1'b1;
					end
				end else begin
					key_now_q  <= '0;
					key_next_q <= kpi_pkg::CNT_W'(1);
				end
			end
			if ((state_q == kpi_pkg::ST_OUT || state_q == kpi_pkg::ST_NULL) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pose.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_cmd.op == kpi_pkg::OP_POSE) begin
			pose_mem[pose_waddr] <= q_cmd.data;
		end
		cur_rd_q <= pose_mem[raddr_cur];
		nxt_rd_q <= pose_mem[raddr_nxt];
		if (pop && q_cmd.op == kpi_pkg::OP_FRAME) begin
			frame_mem[fr_waddr] <= q_cmd.data[15:0];
		end
		fr_rd_q <= frame_mem[fr_raddr];
		if (pop && q_cmd.op == kpi_pkg::OP_HEADER) begin
			hdr_cnt_q[q_cmd.motion]  <= q_cmd.data[kpi_pkg::CNT_W-1:0];
			hdr_loop_q[q_cmd.motion] <= q_cmd.loop_f;
		end
		if (pop && q_cmd.op == kpi_pkg::OP_TICK) begin
			tm_q <= q_cmd.motion;
		end
		unique case (state_q)
			kpi_pkg::ST_CHECK: begin
				frames_q <= frames_c;
				part_q   <= '0;
				axis_q   <= 3'd0;
			end
			kpi_pkg::ST_MUL: begin
				cur_q   <= cur_rd_q;
				prod_s1 <= diff * $signed({1'b0, counter_q});
			end
			kpi_pkg::ST_ABS: begin
				neg_q     <= prod_s1[49];
				num_q     <= prod_s1[49] ? 48'(-prod_s1) : prod_s1[47:0];
				rem_q     <= 16'd0;
				div_cnt_q <= 6'd0;
			end
			kpi_pkg::ST_DIV: begin
				rem_q     <= div_ge ? 16'(rem_sh - {1'b0, frames_q}) : rem_sh[15:0];
				num_q     <= {num_q[46:0], div_ge};
				div_cnt_q <= div_cnt_q + 6'd1;
			end
			kpi_pkg::ST_SUM: begin
				res_q[axis_q] <= sat_v;
				if (axis_q != 3'd5) begin
					axis_q <= axis_q + 3'd1;
				end
			end
			kpi_pkg::ST_OUT: begin
				if (out_free) begin
					out_part_q <= 4'(part_q);
					out_res_q  <= res_q;
					out_pv_q   <= 1'b1;
					out_end_q  <= ended_q;
					out_last_q <= last_part;
					part_q     <= part_q + 1'b1;
					axis_q     <= 3'd0;
				end
			end
			kpi_pkg::ST_NULL: begin
				if (out_free) begin
					out_part_q <= 4'd0;
					for (int i = 0; i < 6; i++) begin
						out_res_q[i] <= 32'sd0;
					end
					out_pv_q   <= 1'b0;
					out_end_q  <= ended_q;
					out_last_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign pose.valid      = out_valid_q;
	assign pose.part_out   = out_part_q;
	assign pose.pos_x      = out_res_q[0];
	assign pose.pos_y      = out_res_q[1];
	assign pose.pos_z      = out_res_q[2];
	assign pose.rot_x      = out_res_q[3];
	assign pose.rot_y      = out_res_q[4];
	assign pose.rot_z      = out_res_q[5];
	assign pose.pose_valid = out_pv_q;
	assign pose.motion_end = out_end_q;
	assign pose.last       = out_last_q;
endmodule
`default_nettype wire

FILE: design/keyframe_pose_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyframe pose interpolator
// Plays keyframed part poses with linear interpolation between keys.
// ----------------------------------------------------------------------------
// Load items are taken one per cycle while the back end is idle, and are written
// when the back end takes them from the queue. A tick runs its setup states and
// then plays each part in turn, its time set by the 48-step serial divider run
// once for each of six components. Reset clears playback, offsets, root flags
// and the part count; the pose, frame and header tables are not cleared.
module keyframe_pose_interpolator (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	kpi_cmd_if.sink                      cmd,
	kpi_pose_if.source                   pose,
	input  wire logic                    cfg_we,
	input  wire logic [kpi_pkg::NP_W-1:0] cfg_wdata
);
	logic [kpi_pkg::NP_W-1:0]   num_parts_q;
	logic [kpi_pkg::PCNT_W-1:0] parts;
	kpi_pkg::cmd_t              f_cmd;
	logic                       f_valid;
	logic                       f_ready;
	kpi_pkg::cmd_t              b_cmd;
	logic                       b_valid;
	logic                       b_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_parts_q <= '0;
		end else if (cfg_we) begin
			num_parts_q <= cfg_wdata;
		end
	end

	assign parts = (32'(num_parts_q) > 32'(kpi_pkg::PARTS)) ?
		kpi_pkg::PCNT_W'(kpi_pkg::PARTS) : kpi_pkg::PCNT_W'(num_parts_q);

	kpi_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_cmd   (f_cmd),
		.q_valid (f_valid),
		.q_ready (f_ready)
	);

	kpi_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cmd   (f_cmd),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.rd_cmd   (b_cmd),
		.rd_valid (b_valid),
		.rd_ready (b_ready)
	);

	kpi_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_cmd   (b_cmd),
		.q_valid (b_valid),
		.q_ready (b_ready),
		.parts   (parts),
		.pose    (pose)
	);

	a_null_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		pose.valid && !pose.pose_valid |-> pose.last)
		else $error("empty result is not the last of its tick");

	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pose.valid && !pose.pose_valid |-> pose.pos_x == 32'sd0 && pose.rot_y == 32'sd0
			&& pose.part_out == 4'd0)
		else $error("empty result carries pose data");

	a_part_range: assert property (@(posedge clk) disable iff (!arst_n)
		pose.valid && pose.pose_valid |-> 32'(pose.part_out) < 32'(parts))
		else $error("part index beyond the configured part count");
endmodule
`default_nettype wire

FILE: tb/kpi_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe pose interpolator test package
// Axis codes of load items and the record of one expected pose item.
// ----------------------------------------------------------------------------
package kpi_tb_pkg;

	localparam logic [3:0] AX_POS_X  = 4'd0;
	localparam logic [3:0] AX_ROT_X  = 4'd3;
	localparam logic [3:0] AX_ROT_Y  = 4'd4;
	localparam logic [3:0] AX_OFF_X  = 4'd6;
	localparam logic [3:0] AX_OFF_Y  = 4'd7;
	localparam logic [3:0] AX_OFF_Z  = 4'd8;
	localparam logic [3:0] AX_ROOT   = 4'd9;
	localparam logic [3:0] AX_UNUSED = 4'd10;

	typedef struct packed {
		logic [3:0]         part;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] rot_x;
		logic signed [31:0] rot_y;
		logic signed [31:0] rot_z;
		logic               pose_valid;
		logic               motion_end;
		logic               last;
	} pose_res_t;

endpackage

FILE: tb/kpi_pose_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe pose checker
// Watches the command, pose and register ports, keeps its own copy of the
// motion tables and playback state, works out the poses of every tick and
// compares each pose item with the oldest one still awaited.
// ----------------------------------------------------------------------------
module kpi_pose_checker
	import kpi_pkg::*;
	import kpi_tb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	kpi_cmd_if                cmd,
	kpi_pose_if               pose,
	input  logic              cfg_we,
	input  logic [NP_W-1:0]   cfg_wdata,
	output int                errors,
	output int                outstanding,
	output int                checked
);

	logic signed [31:0] pose_mem [POSE_DEPTH];
	logic [15:0]        frame_mem [FRAME_DEPTH];
	int                 hdr_keys [MOTIONS];
	bit                 hdr_loop [MOTIONS];
	logic signed [31:0] offset_mem [PARTS*3];
	bit                 root_mem [PARTS];
	int                 cur_motion;
	logic [15:0]        frame_cnt;
	int                 key_now;
	int                 key_next;
	int                 keys_latched;
	int                 parts_cfg;
	pose_res_t          awaited [$];

	function automatic int pose_addr(int m, int k, int p, int a);
		return ((m * KEYS + k) * PARTS + p) * 6 + a;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic void play_tick(int m);
		pose_res_t res [$];
		pose_res_t r;
		bit ended;
		int frames;
		int parts;
		longint cur;
		longint nxt;
		longint v [6];
		ended = 0;
		if (cur_motion != m) begin
			cur_motion = m;
			frame_cnt = 0;
			keys_latched = hdr_keys[m];
			key_now = 0;
			key_next = (keys_latched > 1) ? 1 : 0;
			ended = 1;
		end
		frame_cnt = frame_cnt + 16'd1;
		if (key_next < keys_latched && key_now < KEYS) begin
			frames = frame_mem[m * KEYS + key_now];
			if (frames == 0)
				frames = 1;
			parts = (parts_cfg > PARTS) ? PARTS : parts_cfg;
			for (int q = 0; q < parts; q++) begin
				for (int a = 0; a < 6; a++) begin
					cur = pose_mem[pose_addr(m, key_now, q, a)];
					nxt = pose_mem[pose_addr(m, key_next, q, a)];
					v[a] = cur + ((nxt - cur) * longint'(frame_cnt)) / longint'(frames);
					if (a < 3)
						v[a] += offset_mem[q * 3 + a];
					if (a == 4 && root_mem[q])
						v[a] += PI_Q16;
				end
				r = '0;
				r.part = 4'(q);
				r.pos_x = clamp32(v[0]);
				r.pos_y = clamp32(v[1]);
				r.pos_z = clamp32(v[2]);
				r.rot_x = clamp32(v[3]);
				r.rot_y = clamp32(v[4]);
				r.rot_z = clamp32(v[5]);
				r.pose_valid = 1'b1;
				res.push_back(r);
			end
			if (frame_cnt >= frames) begin
				frame_cnt = 0;
				if (key_next > key_now) begin
					key_next++;
					key_now++;
					ended = 1;
					if (key_now >= hdr_keys[m] - 1)
						key_next = hdr_loop[m] ? 0 : keys_latched;
				end else begin
					key_now = 0;
					key_next = 1;
				end
			end
		end
		if (res.size() == 0)
			res.push_back('0);
		foreach (res[i]) begin
			res[i].motion_end = ended;
			res[i].last = (i == res.size() - 1);
			awaited.push_back(res[i]);
		end
	endfunction

	function automatic void load_item(logic [1:0] mode, int m, int k, int p, int ax,
		logic signed [31:0] value, logic loop_f);
		longint val;
		val = value;
		case (mode)
			MODE_POSE: begin
				if (ax < 6)
					pose_mem[pose_addr(m, k, p, ax)] = value;
				else if (ax < 9)
					offset_mem[p * 3 + ax - 6] = value;
				else if (ax == 9)
					root_mem[p] = (value != 0);
			end
			MODE_FRAME: begin
				if (val < 1)
					val = 1;
				if (val > 65535)
					val = 65535;
				frame_mem[m * KEYS + k] = val[15:0];
			end
			MODE_HEADER: begin
				if (val < 0)
					val = 0;
				if (val > KEYS)
					val = KEYS;
				hdr_keys[m] = int'(val);
				hdr_loop[m] = loop_f;
			end
			default: play_tick(m);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pose_res_t got;
		pose_res_t want;
		if (!arst_n) begin
			foreach (offset_mem[i])
				offset_mem[i] = '0;
			foreach (root_mem[i])
				root_mem[i] = 0;
			cur_motion = MOTIONS;
			frame_cnt = 0;
			key_now = 0;
			key_next = 0;
			keys_latched = 0;
			parts_cfg = 0;
			awaited.delete();
			errors = 0;
			checked = 0;
		end else begin
			if (pose.valid && pose.ready) begin
				got = '{pose.part_out, pose.pos_x, pose.pos_y, pose.pos_z, pose.rot_x,
					pose.rot_y, pose.rot_z, pose.pose_valid, pose.motion_end, pose.last};
				if (awaited.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%t: pose item with none awaited: part %0d", $realtime,
							got.part);
				end else begin
					want = awaited.pop_front();
					checked++;
					if (got !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("%t: pose mismatch, expected part %0d pos %0d %0d %0d rot %0d %0d %0d v%b e%b l%b",
								$realtime, want.part, want.pos_x, want.pos_y, want.pos_z,
								want.rot_x, want.rot_y, want.rot_z, want.pose_valid,
								want.motion_end, want.last);
							$display("%t:   actual part %0d pos %0d %0d %0d rot %0d %0d %0d v%b e%b l%b",
								$realtime, got.part, got.pos_x, got.pos_y, got.pos_z,
								got.rot_x, got.rot_y, got.rot_z, got.pose_valid,
								got.motion_end, got.last);
						end
					end
				end
			end
			if (cfg_we)
				parts_cfg = cfg_wdata;
			if (cmd.valid && cmd.ready)
				load_item(cmd.mode, cmd.motion_type, cmd.key_index, cmd.part_index, cmd.axis,
					cmd.value, cmd.loop_flag);
		end
		outstanding = awaited.size();
	end

endmodule

FILE: tb/tb_keyframe_pose_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe pose interpolator testbench
// Loads a handful of motions, then plays them under several part counts with
// random rewrites of poses, frame counts, headers, offsets and root flags,
// random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_keyframe_pose_interpolator;
	import kpi_pkg::*;
	import kpi_tb_pkg::*;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [NP_W-1:0] cfg_wdata;
	int              errors;
	int              outstanding;
	int              checked;
	bit              calm;
	bit              hold_req;
	int              n_items;
	int              n_ticks;
	int              eff_parts;
	int              last_motion;
	int              key_cnt [5]  = '{2, 4, 3, 1, 0};
	int              part_cnt [5] = '{16, 4, 2, 1, 0};

	kpi_cmd_if  cmd ();
	kpi_pose_if pose ();

	keyframe_pose_interpolator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.pose      (pose),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	kpi_pose_checker pose_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.pose        (pose),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int gap_len();
		int u;
		u = $urandom % 10;
		if (calm || u < 7)
			return 0;
		if (u < 9)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [31:0] pose_word();
		case ($urandom % 6)
			0: return $urandom;
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			default: return $signed($urandom_range(0, 262144)) - 131072;
		endcase
	endfunction

	initial begin
		int cnt;
		pose.ready = 0;
		cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				pose.ready = 0;
				repeat (6000) @(negedge clk);
				hold_req = 0;
			end else if (cnt > 0) begin
				pose.ready = 0;
				cnt--;
			end else begin
				pose.ready = 1;
				cnt = gap_len();
			end
		end
	end

	task automatic send(logic [1:0] mode, int m, int k, int p, int ax,
		logic signed [31:0] value, int loop_f);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			cmd.valid = 0;
			repeat (gap) @(negedge clk);
		end
		cmd.mode = mode;
		cmd.motion_type = 4'(m);
		cmd.key_index = 4'(k);
		cmd.part_index = 4'(p);
		cmd.axis = 4'(ax);
		cmd.value = value;
		cmd.loop_flag = 1'(loop_f);
		cmd.valid = 1;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		@(negedge clk);
		n_items++;
		if (mode == MODE_TICK)
			n_ticks++;
	endtask

	task automatic settle();
		cmd.valid = 0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_parts(int np);
		settle();
		cfg_we = 1;
		cfg_wdata = NP_W'(np);
		@(negedge clk);
		cfg_we = 0;
		eff_parts = (np > PARTS) ? PARTS : np;
	endtask

	function automatic bit playable(int m);
		return key_cnt[m] == 0 || part_cnt[m] >= eff_parts;
	endfunction

	task automatic random_item();
		int u;
		int m;
		u = $urandom % 100;
		if (u < 55) begin
			if (playable(last_motion) && $urandom % 10 < 7)
				m = last_motion;
			else begin
				m = $urandom % 5;
				while (!playable(m))
					m = $urandom % 5;
			end
			last_motion = m;
			send(MODE_TICK, m, $urandom, $urandom, $urandom, $urandom, $urandom);
		end else if (u < 75) begin
			m = $urandom % 4;
			send(MODE_POSE, m, $urandom % key_cnt[m], $urandom % part_cnt[m],
				$urandom % 6, pose_word(), $urandom);
		end else if (u < 82) begin
			m = $urandom % 4;
			send(MODE_FRAME, m, $urandom % key_cnt[m], $urandom,
				$urandom, ($urandom % 8 == 0) ? $signed($urandom) : $urandom_range(0, 4),
				$urandom);
		end else if (u < 87) begin
			m = $urandom % 5;
			send(MODE_HEADER, m, $urandom, $urandom, $urandom,
				$urandom_range(0, key_cnt[m]), $urandom);
		end else if (u < 93) begin
			send(MODE_POSE, $urandom, $urandom, $urandom, $urandom_range(AX_OFF_X, AX_ROOT),
				($urandom % 3 == 0) ? 0 : pose_word(), $urandom);
		end else begin
			case ($urandom % 3)
				0: send(MODE_POSE, $urandom, $urandom, $urandom,
					$urandom_range(AX_UNUSED, 15), $urandom, $urandom);
				1: send(MODE_HEADER, $urandom_range(8, 15), $urandom, $urandom, $urandom,
					$urandom, $urandom);
				default: send(MODE_FRAME, $urandom_range(8, 15), $urandom, $urandom,
					$urandom, $urandom, $urandom);
			endcase
		end
	endtask

	task automatic run_phase(int np, int count);
		set_parts(np);
		calm = ($urandom % 3 == 0);
		repeat (count) random_item();
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		cmd.valid = 0;
		cmd.mode = MODE_POSE;
		cmd.motion_type = 0;
		cmd.key_index = 0;
		cmd.part_index = 0;
		cmd.axis = 0;
		cmd.value = 0;
		cmd.loop_flag = 0;
		calm = 0;
		hold_req = 0;
		n_items = 0;
		n_ticks = 0;
		eff_parts = 0;
		last_motion = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		for (int m = 0; m < 5; m++) begin
			send(MODE_HEADER, m, 0, 0, 0, key_cnt[m], m != 2);
			for (int k = 0; k < key_cnt[m]; k++) begin
				send(MODE_FRAME, m, k, 0, 0, (m == 1 && k == 0) ? 0 : $urandom_range(1, 3), 0);
				for (int p = 0; p < part_cnt[m]; p++)
					for (int a = 0; a < 6; a++)
						send(MODE_POSE, m, k, p, a, pose_word(), 0);
			end
		end

		send(MODE_POSE, 0, 0, 0, AX_OFF_X, 32'sh7fffffff, 0);
		send(MODE_POSE, 0, 0, 0, AX_OFF_Y, 32'sh80000000, 0);
		send(MODE_POSE, 0, 0, 0, AX_OFF_Z, 100, 0);
		send(MODE_POSE, 0, 0, 0, AX_ROOT, 32'sh80000000, 0);
		send(MODE_POSE, 0, 0, 1, AX_ROOT, 1, 0);
		send(MODE_POSE, 0, 0, 15, AX_OFF_Z, -7, 0);
		send(MODE_POSE, 15, 15, 15, AX_UNUSED, 32'sh7fffffff, 1);
		send(MODE_POSE, 15, 15, 15, 15, -1, 1);
		send(MODE_HEADER, 15, 15, 15, 0, 1000, 1);
		send(MODE_HEADER, 14, 0, 0, 0, 32'sh80000000, 0);
		send(MODE_FRAME, 6, 0, 0, 0, 0, 0);
		send(MODE_FRAME, 6, 1, 0, 0, -5, 0);
		send(MODE_FRAME, 6, 2, 0, 0, 70000, 0);
		send(MODE_FRAME, 15, 15, 0, 0, 32'sh7fffffff, 0);
		send(MODE_TICK, 4, 0, 0, 0, 0, 0);
		send(MODE_TICK, 0, 0, 0, 0, 0, 0);
		send(MODE_TICK, 0, 0, 0, 0, 0, 0);

		set_parts(1);
		send(MODE_TICK, 3, 0, 0, 0, 0, 0);
		send(MODE_TICK, 2, 0, 0, 0, 0, 0);
		repeat (6) send(MODE_TICK, 2, 0, 0, 0, 0, 0);

		run_phase(1, 8);
		run_phase(16, 4);
		hold_req = 1;
		repeat (6) send(MODE_TICK, 0, 0, 0, 0, 0, 0);
		run_phase(0, 6);
		run_phase(31, 4);
		run_phase(3, 8);
		run_phase(2, 8);
		run_phase(4, 8);
		run_phase(5, 3);
		run_phase(1, 6);

		settle();
		repeat (50) @(negedge clk);
		$display("Sent %0d items, %0d of them ticks, under part counts 0 to 31.", n_items,
			n_ticks);
		$display("Compared %0d pose items against the predicted poses.", checked);
		if (errors == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: keyframe_pose_interpolator.f
design/kpi_pkg.sv
design/kpi_cmd_if.sv
design/kpi_pose_if.sv
design/kpi_front.sv
design/kpi_queue.sv
design/kpi_back.sv
design/keyframe_pose_interpolator.sv
tb/kpi_tb_pkg.sv
tb/kpi_pose_checker.sv
tb/tb_keyframe_pose_interpolator.sv
